// ===== rtl/core/mfpd_pkg.sv =====
// shared types and constants for the motor fader pid drive
// depends on nothing; imported by every module of the block

package mfpd_pkg;

	// payload widths
	localparam int POS_W   = 10;
	localparam int ERR_W   = 11;
	localparam int DIFF_W  = 12;
	localparam int DTERM_W = 24;
	localparam int INTEG_W = 29;
	localparam int OPA_W   = 29;
	localparam int OPB_W   = 17;
	localparam int PROD_W  = OPA_W + OPB_W;
	localparam int ACC_W   = 42;
	localparam int MAG_W   = 22;
	localparam int SUM5_W  = 13;

	// beat widths
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;

	// reciprocal of five in q15, exact for sums below 5116
	localparam logic signed [OPB_W-1:0] RECIP5 = 17'sd6554;
	// integrator clamp, 1000.0 in q12.16
	localparam logic signed [INTEG_W:0] INTEG_LIMIT = 30'sd65536000;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN   = 3'd0,
		REG_INTEG_GAIN  = 3'd1,
		REG_DERIV_GAIN  = 3'd2,
		REG_OUTPUT_GAIN = 3'd3,
		REG_INTEG_LEAK  = 3'd4,
		REG_DERIV_SCALE = 3'd5,
		REG_TOLERANCE   = 3'd6,
		REG_MIN_DRIVE   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [15:0] prop_gain;
		logic signed [15:0] integ_gain;
		logic signed [15:0] deriv_gain;
		logic [11:0]        output_gain;
		logic [15:0]        integ_leak;
		logic [11:0]        deriv_scale;
		logic [9:0]         tolerance;
		logic [9:0]         min_drive;
	} cfg_t;

	// sequencer states, one step of the tick each
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GOAL_M,
		ST_ERR,
		ST_INT_M,
		ST_INT_W,
		ST_D_W,
		ST_P_W,
		ST_I_W,
		ST_D_ACC,
		ST_MAG,
		ST_SPD_M,
		ST_OUT
	} state_t;

	// operand pair for the shared multiplier
	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_GOAL,
		MUL_INT,
		MUL_DIFF,
		MUL_PROP,
		MUL_IGAIN,
		MUL_DGAIN,
		MUL_SPEED
	} mul_sel_t;

	// which write-back the datapath does in each step, mostly of the last product
	typedef enum logic [3:0] {
		WB_NONE,
		WB_GOAL,
		WB_DIFF,
		WB_INTEG,
		WB_DTERM,
		WB_ACC_P,
		WB_ACC_I,
		WB_ACC_D,
		WB_MAG
	} wb_sel_t;

	typedef struct packed {
		logic     load_in;
		logic     load_out;
		mul_sel_t mul_sel;
		wb_sel_t  wb_sel;
	} dp_cmd_t;

endpackage

// ===== rtl/core/mfpd_regs.sv =====
// configuration register bank of the motor fader pid drive
// depends on mfpd_pkg

module mfpd_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mfpd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mfpd_pkg::CFG_DAT_W-1:0] cfg_data,
	output mfpd_pkg::cfg_t                cfg
);
	import mfpd_pkg::*;

	cfg_t cfg_q;

	// register writes, decoded by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain   <= 16'sd12288;
			cfg_q.integ_gain  <= 16'sd82;
			cfg_q.deriv_gain  <= -16'sd246;
			cfg_q.output_gain <= 12'd500;
			cfg_q.integ_leak  <= 16'd64225;
			cfg_q.deriv_scale <= 12'd1000;
			cfg_q.tolerance   <= 10'd3;
			cfg_q.min_drive   <= 10'd400;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_PROP_GAIN:   cfg_q.prop_gain   <= cfg_data;
				REG_INTEG_GAIN:  cfg_q.integ_gain  <= cfg_data;
				REG_DERIV_GAIN:  cfg_q.deriv_gain  <= cfg_data;
				REG_OUTPUT_GAIN: cfg_q.output_gain <= cfg_data[11:0];
				REG_INTEG_LEAK:  cfg_q.integ_leak  <= cfg_data;
				REG_DERIV_SCALE: cfg_q.deriv_scale <= cfg_data[11:0];
				REG_TOLERANCE:   cfg_q.tolerance   <= cfg_data[9:0];
				REG_MIN_DRIVE:   cfg_q.min_drive   <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/mfpd_ctrl.sv =====
// sequencer of the motor fader pid drive: steps one tick through the datapath
// depends on mfpd_pkg

module mfpd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              m_tready,
	input  logic              out_valid,
	output logic              in_ready,
	output mfpd_pkg::dp_cmd_t cmd
);
	import mfpd_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_free;

	assign out_free = !out_valid || m_tready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and datapath commands
	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		cmd.load_in  = 1'b0;
		cmd.load_out = 1'b0;
		cmd.mul_sel  = MUL_NONE;
		cmd.wb_sel   = WB_NONE;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_GOAL_M;
				end
			end
			ST_GOAL_M: begin
				cmd.mul_sel = MUL_GOAL;
				state_d     = ST_ERR;
			end
			ST_ERR: begin
				cmd.wb_sel = WB_GOAL;
				state_d    = ST_INT_M;
			end
			ST_INT_M: begin
				cmd.mul_sel = MUL_INT;
				cmd.wb_sel  = WB_DIFF;
				state_d     = ST_INT_W;
			end
			ST_INT_W: begin
				cmd.wb_sel  = WB_INTEG;
				cmd.mul_sel = MUL_DIFF;
				state_d     = ST_D_W;
			end
			ST_D_W: begin
				cmd.wb_sel  = WB_DTERM;
				cmd.mul_sel = MUL_PROP;
				state_d     = ST_P_W;
			end
			ST_P_W: begin
				cmd.wb_sel  = WB_ACC_P;
				cmd.mul_sel = MUL_IGAIN;
				state_d     = ST_I_W;
			end
			ST_I_W: begin
				cmd.wb_sel  = WB_ACC_I;
				cmd.mul_sel = MUL_DGAIN;
				state_d     = ST_D_ACC;
			end
			ST_D_ACC: begin
				cmd.wb_sel = WB_ACC_D;
				state_d    = ST_MAG;
			end
			ST_MAG: begin
				cmd.wb_sel = WB_MAG;
				state_d    = ST_SPD_M;
			end
			ST_SPD_M: begin
				cmd.mul_sel = MUL_SPEED;
				state_d     = ST_OUT;
			end
			ST_OUT: begin
				// wait here while the previous result is still held
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// result register is never overwritten while it holds an untaken beat
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid || m_tready))
		else $error("result loaded over a pending beat");

	// one tick at a time: no accept right after an accept
	a_one_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && in_ready) |=> !in_ready)
		else $error("second beat accepted during a tick");

	// a result is only produced for a tick that was started
	a_out_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !in_ready)
		else $error("result produced while idle");

endmodule

// ===== rtl/core/mfpd_dp.sv =====
// datapath of the motor fader pid drive: loop state, one shared multiplier,
// accumulator and result register; depends on mfpd_pkg

module mfpd_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mfpd_pkg::cfg_t                 cfg,
	input  mfpd_pkg::dp_cmd_t              cmd,
	input  logic [mfpd_pkg::S_DATA_W-1:0]  s_tdata,
	input  logic                           m_tready,
	output logic                           out_valid,
	output logic [mfpd_pkg::M_DATA_W-1:0]  m_tdata
);
	import mfpd_pkg::*;

	// input beat
	logic [POS_W-1:0] tgt_q;
	logic [POS_W-1:0] meas_q;
	logic             touch_q;
	logic             allow_q;

	// loop state
	logic [POS_W-1:0]          goal_q;
	logic signed [INTEG_W-1:0] integ_q;
	logic signed [ERR_W-1:0]   prev_q;

	// per-tick working registers
	logic signed [ERR_W-1:0]   err_q;
	logic signed [DIFF_W-1:0]  diff_q;
	logic signed [DTERM_W-1:0] d_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic [MAG_W-1:0]          mag_q;
	logic                      big_q;
	logic                      pos_q;
	logic signed [PROD_W-1:0]  p_q;

	// result register
	logic                out_valid_q;
	logic [POS_W-1:0]    up_q;
	logic [POS_W-1:0]    down_q;
	logic                en_q;
	logic [POS_W-1:0]    smooth_q;

	logic [SUM5_W-1:0]         sum5;
	logic signed [INTEG_W-1:0] isum;
	logic signed [OPA_W-1:0]   op_a;
	logic signed [OPB_W-1:0]   op_b;
	logic signed [PROD_W-1:0]  prod;
	logic [POS_W-1:0]          goal_new;
	logic signed [INTEG_W:0]   ish;
	logic signed [ACC_W-1:0]   acc_abs;
	logic                      og_nz;
	logic                      sat;
	logic [POS_W-1:0]          spd_raw;
	logic [POS_W-1:0]          speed;
	logic [ERR_W-1:0]          err_abs;
	logic                      outside;
	logic                      go_up;

	// 4*goal + target for the smoothing step
	assign sum5 = {1'b0, goal_q, 2'b00} + {3'b000, tgt_q};
	// integrator plus error in q12.16
	assign isum = integ_q + {{2{err_q[ERR_W-1]}}, err_q, 16'h0000};

	// operand select for the shared multiplier
	always_comb begin
		case (cmd.mul_sel)
			MUL_GOAL: begin
				op_a = {{(OPA_W-SUM5_W){1'b0}}, sum5};
				op_b = RECIP5;
			end
			MUL_INT: begin
				op_a = isum;
				op_b = {1'b0, cfg.integ_leak};
			end
			MUL_DIFF: begin
				op_a = {{(OPA_W-DIFF_W){diff_q[DIFF_W-1]}}, diff_q};
				op_b = {5'b00000, cfg.deriv_scale};
			end
			MUL_PROP: begin
				op_a = {{(OPA_W-ERR_W){err_q[ERR_W-1]}}, err_q};
				op_b = {cfg.prop_gain[15], cfg.prop_gain};
			end
			MUL_IGAIN: begin
				op_a = integ_q;
				op_b = {cfg.integ_gain[15], cfg.integ_gain};
			end
			MUL_DGAIN: begin
				op_a = {{(OPA_W-DTERM_W){d_q[DTERM_W-1]}}, d_q};
				op_b = {cfg.deriv_gain[15], cfg.deriv_gain};
			end
			MUL_SPEED: begin
				op_a = {{(OPA_W-MAG_W){1'b0}}, mag_q};
				op_b = {5'b00000, cfg.output_gain};
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign prod = op_a * op_b;

	// write-back helpers
	assign goal_new = p_q[24:15];
	assign ish      = p_q[PROD_W-1:16];
	assign acc_abs  = acc_q[ACC_W-1] ? -acc_q : acc_q;

	// final speed and direction
	assign og_nz   = |cfg.output_gain;
	assign sat     = (big_q && og_nz) || (|p_q[33:22]);
	assign spd_raw = sat ? {POS_W{1'b1}} : p_q[21:12];
	assign speed   = (spd_raw < cfg.min_drive) ? cfg.min_drive : spd_raw;
	assign err_abs = err_q[ERR_W-1] ? -err_q : err_q;
	assign outside = err_abs > {1'b0, cfg.tolerance};
	assign go_up   = pos_q && og_nz;

	// loop state, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_q  <= '0;
			integ_q <= '0;
			prev_q  <= '0;
		end else begin
			case (cmd.wb_sel)
				WB_GOAL: goal_q <= goal_new;
				WB_DIFF: prev_q <= err_q;
				WB_INTEG: begin
					if (ish > INTEG_LIMIT) begin
						integ_q <= INTEG_LIMIT[INTEG_W-1:0];
					end else if (ish < -INTEG_LIMIT) begin
						integ_q <= INTEG_W'(-INTEG_LIMIT);
					end else begin
						integ_q <= ish[INTEG_W-1:0];
					end
				end
				default: ;
			endcase
		end
	end

	// input beat and working registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			tgt_q   <= s_tdata[9:0];
			meas_q  <= s_tdata[19:10];
			touch_q <= s_tdata[20];
			allow_q <= s_tdata[21];
		end
		if (cmd.mul_sel != MUL_NONE) begin
			p_q <= prod;
		end
		case (cmd.wb_sel)
			WB_GOAL:  err_q  <= {1'b0, goal_new} - {1'b0, meas_q};
			WB_DIFF:  diff_q <= {prev_q[ERR_W-1], prev_q} - {err_q[ERR_W-1], err_q};
			WB_DTERM: d_q    <= p_q[DTERM_W-1:0];
			WB_ACC_P: acc_q  <= p_q[ACC_W-1:0];
			WB_ACC_I: acc_q  <= acc_q + {{(ACC_W-INTEG_W-1){ish[INTEG_W]}}, ish};
			WB_ACC_D: acc_q  <= acc_q + p_q[ACC_W-1:0];
			WB_MAG: begin
				mag_q <= acc_abs[MAG_W-1:0];
				big_q <= |acc_abs[ACC_W-1:MAG_W];
				pos_q <= !acc_q[ACC_W-1] && (acc_q != '0);
			end
			default: ;
		endcase
		if (cmd.load_out) begin
			up_q     <= (outside && go_up) ? speed : '0;
			down_q   <= (outside && !go_up) ? speed : '0;
			en_q     <= outside && allow_q && !touch_q;
			smooth_q <= goal_q;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign m_tdata   = {1'b0, smooth_q, en_q, down_q, up_q};

	// integrator never leaves its clamp
	a_integ_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(integ_q <= $signed(INTEG_LIMIT[INTEG_W-1:0])) &&
		(integ_q >= INTEG_W'(-INTEG_LIMIT)))
		else $error("integrator outside clamp");

	// only one bridge side is driven
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((up_q == '0) || (down_q == '0)))
		else $error("both bridge sides driven");

	// a loaded result is offered on the next cycle
	a_out_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q)
		else $error("loaded result not offered");

endmodule

// ===== rtl/core/motor_fader_pid_drive.sv =====
// top level of the motor fader pid drive
// depends on mfpd_pkg, mfpd_regs, mfpd_ctrl, mfpd_dp
//
//  channel  | signals                         | beat content
//  ---------+---------------------------------+------------------------------------
//  s        | s_tvalid s_tready s_tdata[23:0] | one control tick: target, measured,
//           |                                 | touched, motor_allowed
//  m        | m_tvalid m_tready m_tdata[31:0] | duty_up, duty_down, bridge_enable,
//           |                                 | smoothed_target
//  cfg      | cfg_we cfg_index cfg_data       | gain, leak, band and duty registers
//
// a tick runs from accept to the next accept through eleven steps of the
// sequencer, set by seven passes through the single shared 29x17 multiplier
// and the writes that consume each product.
// s_tready is high only while the sequencer is idle; a new tick is taken while
// the previous result still waits on m.
// a tick that finishes while m is stalled waits in its last step.
// arst_n clears the loop state (smoothed goal, integrator, previous error) and
// loads the register reset values.

module motor_fader_pid_drive (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [9:0] target_position, [19:10] measured_position, [20] touched,
	// [21] motor_allowed, [23:22] zero
	input  logic [mfpd_pkg::S_DATA_W-1:0]  s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [9:0] duty_up, [19:10] duty_down, [20] bridge_enable,
	// [30:21] smoothed_target, [31] zero
	output logic [mfpd_pkg::M_DATA_W-1:0]  m_tdata,
	input  logic                           cfg_we,
	input  logic [mfpd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mfpd_pkg::CFG_DAT_W-1:0] cfg_data
);
	import mfpd_pkg::*;

	cfg_t    cfg;
	dp_cmd_t cmd;
	logic    out_valid;
	logic    in_ready;

	// configuration registers
	mfpd_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// tick sequencer
	mfpd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.m_tready  (m_tready),
		.out_valid (out_valid),
		.in_ready  (in_ready),
		.cmd       (cmd)
	);

	// arithmetic and loop state
	mfpd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.s_tdata   (s_tdata),
		.m_tready  (m_tready),
		.out_valid (out_valid),
		.m_tdata   (m_tdata)
	);

	assign s_tready = in_ready;
	assign m_tvalid = out_valid;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// self-checking bench for motor_fader_pid_drive: stream driver, result monitor, loop predictor
// depends on mfpd_pkg for the register index enum and the register bank struct

module tb_top;
	import mfpd_pkg::*;

	localparam longint INTEG_CLAMP = 64'sd65536000;

	typedef struct packed {
		logic       motor_allowed;
		logic       touched;
		logic [9:0] measured;
		logic [9:0] target;
	} tick_t;

	typedef struct packed {
		logic [9:0] smoothed;
		logic       bridge_enable;
		logic [9:0] duty_down;
		logic [9:0] duty_up;
	} drive_t;

	typedef enum int {SET_LOW, SET_HIGH, SET_FULL, SET_NEAR} reg_style_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	// predictor copy of the loop state and registers
	cfg_t   loop_cfg;
	int     goal_now;
	longint integ_acc;
	longint err_last;

	tick_t  tick_feed[$];
	drive_t drive_due[$];
	tick_t  tick_now;

	int s_idle_max = 0;
	int m_idle_max = 0;
	int s_gap = 0;
	int m_stall = 0;
	int ticks_queued = 0;
	int ticks_sent = 0;
	int drives_seen = 0;
	int driven_seen = 0;
	int band_seen = 0;
	int settings_used = 0;
	int err_count = 0;

	motor_fader_pid_drive DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// one control tick of the fader loop, updating the predictor state
	function automatic drive_t step_fader_loop(input tick_t t);
		longint err, dterm, pid_sum, drive, mag, speed, err_mag;
		drive_t r;
		goal_now = (4 * goal_now + int'(t.target)) / 5;
		err = longint'(goal_now) - longint'(t.measured);

		integ_acc = ((integ_acc + err * 65536) * longint'(loop_cfg.integ_leak)) >>> 16;
		if (integ_acc > INTEG_CLAMP)
			integ_acc = INTEG_CLAMP;
		if (integ_acc < -INTEG_CLAMP)
			integ_acc = -INTEG_CLAMP;

		dterm = (err_last - err) * longint'(loop_cfg.deriv_scale);
		pid_sum = longint'($signed(loop_cfg.prop_gain)) * err
			+ ((longint'($signed(loop_cfg.integ_gain)) * integ_acc) >>> 16)
			+ longint'($signed(loop_cfg.deriv_gain)) * dterm;
		drive = pid_sum * longint'(loop_cfg.output_gain);
		err_last = err;

		mag = (drive < 0) ? -drive : drive;
		speed = mag >>> 12;
		if (speed > 1023)
			speed = 1023;
		if (speed < longint'(loop_cfg.min_drive))
			speed = longint'(loop_cfg.min_drive);

		r = '0;
		err_mag = (err < 0) ? -err : err;
		// outside the dead band one bridge side is driven, zero drive counts as down
		if (err_mag > longint'(loop_cfg.tolerance)) begin
			if (drive > 0)
				r.duty_up = 10'(speed);
			else
				r.duty_down = 10'(speed);
			r.bridge_enable = !t.touched && t.motor_allowed;
		end
		r.smoothed = 10'(goal_now);
		return r;
	endfunction

	function automatic int pin10(input int v);
		if (v < 0)
			return 0;
		if (v > 1023)
			return 1023;
		return v;
	endfunction

	task automatic cmp_field(input string what, input logic [9:0] want, input logic [9:0] got);
		if (want !== got) begin
			$display("%0t mismatch %s expected %0d actual %0d", $time, what, want, got);
			err_count++;
		end
	endtask

	// register write, mirrored into the predictor bank
	task automatic load_reg(input reg_idx_t idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_PROP_GAIN:   loop_cfg.prop_gain = val;
			REG_INTEG_GAIN:  loop_cfg.integ_gain = val;
			REG_DERIV_GAIN:  loop_cfg.deriv_gain = val;
			REG_OUTPUT_GAIN: loop_cfg.output_gain = val[11:0];
			REG_INTEG_LEAK:  loop_cfg.integ_leak = val;
			REG_DERIV_SCALE: loop_cfg.deriv_scale = val[11:0];
			REG_TOLERANCE:   loop_cfg.tolerance = val[9:0];
			REG_MIN_DRIVE:   loop_cfg.min_drive = val[9:0];
			default: ;
		endcase
	endtask

	task automatic end_writes;
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// value for one register: an extreme, anything legal, or close to a usable tune
	function automatic logic [15:0] pick_reg_value(input reg_idx_t idx, input reg_style_t style);
		int full_lo, full_hi, near_lo, near_hi, v;
		case (idx)
			REG_PROP_GAIN:   begin full_lo = -32768; full_hi = 32767; near_lo = 4096; near_hi = 20480; end
			REG_INTEG_GAIN:  begin full_lo = -32768; full_hi = 32767; near_lo = 0; near_hi = 400; end
			REG_DERIV_GAIN:  begin full_lo = -32768; full_hi = 32767; near_lo = -600; near_hi = 0; end
			REG_OUTPUT_GAIN: begin full_lo = 0; full_hi = 4095; near_lo = 100; near_hi = 900; end
			REG_INTEG_LEAK:  begin full_lo = 0; full_hi = 65535; near_lo = 60000; near_hi = 65535; end
			REG_DERIV_SCALE: begin full_lo = 0; full_hi = 4095; near_lo = 0; near_hi = 2000; end
			REG_TOLERANCE:   begin full_lo = 0; full_hi = 1023; near_lo = 0; near_hi = 8; end
			default:         begin full_lo = 0; full_hi = 1023; near_lo = 0; near_hi = 600; end
		endcase
		case (style)
			SET_LOW:  v = full_lo;
			SET_HIGH: v = full_hi;
			SET_FULL: v = full_lo + int'($urandom_range(0, full_hi - full_lo));
			default:  v = near_lo + int'($urandom_range(0, near_hi - near_lo));
		endcase
		return 16'(v);
	endfunction

	task automatic push_tick(input int tgt, input int meas, input bit touch, input bit allow);
		tick_t t;
		t.target = 10'(tgt);
		t.measured = 10'(meas);
		t.touched = touch;
		t.motor_allowed = allow;
		tick_feed.push_back(t);
		ticks_queued++;
	endtask

	// mostly a wiper settling around a held target, some sustained error, some noise
	task automatic queue_ticks(input int n);
		int aim, sel, meas, tgt;
		aim = $urandom_range(0, 1023);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 15) == 0)
				aim = $urandom_range(0, 1023);
			sel = $urandom_range(0, 9);
			tgt = aim;
			if (sel < 6)
				meas = pin10(aim + int'($urandom_range(0, 16)) - 8);
			else if (sel < 8)
				meas = pin10(aim + int'($urandom_range(0, 400)) - 200);
			else begin
				tgt = $urandom_range(0, 1023);
				meas = $urandom_range(0, 1023);
			end
			push_tick(tgt, meas, $urandom_range(0, 4) == 0, $urandom_range(0, 4) != 0);
		end
	endtask

	task automatic drain;
		while (drives_seen != ticks_queued)
			@(posedge clk);
	endtask

	// input driver with per-beat idle gaps, predicts each accepted beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_gap = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				drive_due.push_back(step_fader_loop(tick_now));
				ticks_sent++;
				s_gap = $urandom_range(0, s_idle_max);
			end
			if (!s_tvalid || s_tready) begin
				if (s_gap == 0 && tick_feed.size() > 0) begin
					tick_now = tick_feed.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {2'b00, tick_now};
				end else begin
					s_tvalid <= 1'b0;
					if (s_gap > 0)
						s_gap--;
				end
			end
		end
	end

	// result monitor with per-beat stalls
	always @(posedge clk or negedge arst_n) begin
		drive_t got, want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			m_stall = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[30:0];
				drives_seen++;
				if (drive_due.size() == 0) begin
					$display("%0t unexpected result beat %h", $time, m_tdata);
					err_count++;
				end else begin
					want = drive_due.pop_front();
					cmp_field("duty_up", want.duty_up, got.duty_up);
					cmp_field("duty_down", want.duty_down, got.duty_down);
					cmp_field("bridge_enable", {9'd0, want.bridge_enable}, {9'd0, got.bridge_enable});
					cmp_field("smoothed_target", want.smoothed, got.smoothed);
					if (want.bridge_enable)
						driven_seen++;
					if (want.duty_up == 0 && want.duty_down == 0)
						band_seen++;
				end
				m_stall = $urandom_range(0, m_idle_max);
			end
			if (m_stall > 0) begin
				m_tready <= 1'b0;
				m_stall--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// run limit
	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	// stimulus sequence
	initial begin
		reg_style_t style;
		loop_cfg.prop_gain = 16'sd12288;
		loop_cfg.integ_gain = 16'sd82;
		loop_cfg.deriv_gain = -16'sd246;
		loop_cfg.output_gain = 12'd500;
		loop_cfg.integ_leak = 16'd64225;
		loop_cfg.deriv_scale = 12'd1000;
		loop_cfg.tolerance = 10'd3;
		loop_cfg.min_drive = 10'd400;
		goal_now = 0;
		integ_acc = 0;
		err_last = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		settings_used = 1;

		// reset tune: dead band, its edge, both directions, touch and allow combinations
		push_tick(0, 0, 0, 1);
		push_tick(0, 3, 0, 1);
		push_tick(0, 4, 0, 1);
		repeat (4) push_tick(1023, 0, 0, 1);
		push_tick(1023, 0, 1, 1);
		push_tick(1023, 0, 1, 0);
		push_tick(1023, 0, 0, 0);
		repeat (3) push_tick(0, 1023, 0, 1);
		push_tick(512, 1023, 0, 1);
		drain();

		// zero gains outside the band: the down side gets the minimum duty
		load_reg(REG_PROP_GAIN, 16'd0);
		load_reg(REG_INTEG_GAIN, 16'd0);
		load_reg(REG_DERIV_GAIN, 16'd0);
		load_reg(REG_TOLERANCE, 16'd0);
		load_reg(REG_MIN_DRIVE, 16'd777);
		end_writes();
		push_tick(1023, 0, 0, 1);
		push_tick(0, 1023, 0, 1);
		push_tick(0, 0, 0, 1);
		drain();

		// random phases, each with a fresh register set and idle pattern
		for (int p = 0; p < 10; p++) begin
			s_idle_max = (p % 4 == 0 || p % 4 == 2) ? 18 : 0;
			m_idle_max = (p % 4 == 0 || p % 4 == 3) ? 18 : 0;
			for (int r = 0; r < 8; r++) begin
				case (p)
					0: style = SET_NEAR;
					1: style = SET_HIGH;
					2: style = SET_LOW;
					3: style = SET_FULL;
					default: style = reg_style_t'(($urandom_range(0, 5) > 3) ?
						$urandom_range(0, 2) : SET_NEAR);
				endcase
				load_reg(reg_idx_t'(r), pick_reg_value(reg_idx_t'(r), style));
			end
			end_writes();
			queue_ticks(65);
			drain();
		end

		// tail for anything stray
		repeat (40) @(posedge clk);
		if (drive_due.size() != 0) begin
			$display("%0t %0d expected results never arrived", $time, drive_due.size());
			err_count++;
		end
		$display("covered %0d ticks under %0d register sets", ticks_sent, settings_used);
		$display("%0d ticks drove the bridge, %0d left both duties at zero", driven_seen, band_seen);
		if (err_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
